### src/gwm_pkg.sv
package gwm_pkg;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHARS_LOW      = 3'd0,
    REG_CHARS_MID_LOW  = 3'd1,
    REG_CHARS_MID_HIGH = 3'd2,
    REG_CHARS_HIGH     = 3'd3,
    REG_LENGTH         = 3'd4,
    REG_FOLD_CASE      = 3'd5
  } cfg_reg_t;

  // Per-element decode handed from a cell to the top level
  typedef struct packed {
    logic bad;   // unterminated bracket class starts here
    logic wild;  // '*' or '?'
  } elem_flags_t;

  // ASCII lower-casing when enabled
  function automatic logic [7:0] fold_byte(input logic en, input logic [7:0] c);
    if (en && c >= 8'h41 && c <= 8'h5A) return c + 8'd32;
    return c;
  endfunction

endpackage

### src/glob_wildcard_matcher.sv
// Glob matcher: one name byte per item, one item per cycle, results registered on
// the name-end item. A row of PATTERN_MAX+1 position cells holds the active set; each
// cycle every cell decodes its pattern element against the byte and drives the set
// for the next byte, with empty matches of '*' and '?' carried cell to cell. Input
// stalls only while a result is held and the output side stalls.
module glob_wildcard_matcher import gwm_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           name_byte,
  input  logic                 name_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 matched,
  output logic                 pattern_bad,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int N  = PATTERN_MAX;
  localparam int PW = $clog2(N + 2);

  logic [63:0] pat_low, pat_mid_low, pat_mid_high, pat_high;
  logic [5:0]  pat_len;
  logic        fold_en;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low <= '0;
      pat_mid_low <= '0;
      pat_mid_high <= '0;
      pat_high <= '0;
      pat_len <= '0;
      fold_en <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_CHARS_LOW:      pat_low <= cfg_data;
        REG_CHARS_MID_LOW:  pat_mid_low <= cfg_data;
        REG_CHARS_MID_HIGH: pat_mid_high <= cfg_data;
        REG_CHARS_HIGH:     pat_high <= cfg_data;
        REG_LENGTH:         pat_len <= cfg_data[5:0];
        REG_FOLD_CASE:      fold_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pattern bytes, padded with zeros past the registers
  logic [255:0] pat_flat;
  logic [7:0]   patx [N+3];
  assign pat_flat = {pat_high, pat_mid_high, pat_mid_low, pat_low};
  always_comb begin
    for (int i = 0; i < N + 3; i++) begin
      patx[i] = (i < 32) ? pat_flat[(i % 32) * 8 +: 8] : 8'h00;
    end
  end

  // Effective length, clamped to capacity
  logic [PW-1:0] n;
  assign n = (int'(pat_len) > N) ? PW'(N) : PW'(pat_len);

  // Handshake
  logic in_acc, step, restart;
  assign in_stall = out_valid && out_stall;
  assign in_acc = in_valid && !in_stall;
  assign step = in_acc && !name_end;
  assign restart = in_acc && name_end;

  // Cell row
  logic [N+1:0]  carry;
  logic [N:0]    cur;
  logic [N:0]    drive [N+1];
  logic [N:0]    act_next;
  logic [PW-1:0] end_pos [N+1];
  elem_flags_t   flags [N+1];

  assign carry[0] = 1'b0;

  for (genvar p = 0; p <= N; p++) begin : g_cell
    gwm_cell #(.N(N), .P(p), .PW(PW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .patx     (patx),
      .n        (n),
      .fold_en  (fold_en),
      .c        (name_byte),
      .step     (step),
      .restart  (restart),
      .act_next (act_next[p]),
      .carry_in (carry[p]),
      .carry_out(carry[p+1]),
      .cur      (cur[p]),
      .drive    (drive[p]),
      .end_pos  (end_pos[p]),
      .flags    (flags[p])
    );
  end

  // Gather drives into the next active set
  always_comb begin
    act_next = '0;
    for (int p = 0; p <= N; p++) begin
      act_next = act_next | drive[p];
    end
  end

  // Walk element starts from position zero looking for an unterminated class
  logic [N+1:0] on;
  logic         bad;
  always_comb begin
    on = '0;
    on[0] = 1'b1;
    bad = 1'b0;
    for (int p = 0; p < N; p++) begin
      if (on[p] && p < int'(n)) begin
        if (flags[p].bad) bad = 1'b1;
        else on[end_pos[p]] = 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (restart) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (restart) begin
      matched <= !bad && cur[n];
      pattern_bad <= bad;
    end
  end

endmodule

### src/gwm_cell.sv
// One pattern position: active bit, element decode, close carry to the right.
module gwm_cell import gwm_pkg::*; #(
  parameter int N   = 32,
  parameter int P   = 0,
  parameter int PW  = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    patx [N+3],
  input  logic [PW-1:0] n,
  input  logic          fold_en,
  input  logic [7:0]    c,
  input  logic          step,      // accepted name byte
  input  logic          restart,   // accepted name end
  input  logic          act_next,  // OR of drives aimed at this position
  input  logic          carry_in,
  output logic          carry_out,
  output logic          cur,
  output logic [N:0]    drive,
  output logic [PW-1:0] end_pos,
  output elem_flags_t   flags
);

  logic active;
  logic hit;
  logic cls_bad;
  int   endq;

  // Position state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= (P == 0);
    end else if (restart) begin
      active <= (P == 0);
    end else if (step) begin
      active <= act_next;
    end
  end

  // Element decode, bracket class parsed from this position
  always_comb begin
    logic [7:0]  b, fc, x;
    logic [N+3:0] ms;
    logic neg, found, done, rng;
    int q0;
    b = patx[P];
    fc = fold_byte(fold_en, c);
    ms = '0;
    neg = 1'b0;
    found = 1'b0;
    done = 1'b0;
    rng = 1'b0;
    x = '0;
    q0 = P + 1;
    endq = P + 1;
    cls_bad = 1'b0;
    hit = 1'b0;
    if (b == CH_STAR || b == CH_QMARK) begin
      hit = 1'b1;
    end else if (b != CH_LBRACK) begin
      hit = (fold_byte(fold_en, b) == fc);
    end else begin
      if ((P + 1) < int'(n) && patx[P+1] == CH_CARET) begin
        neg = 1'b1;
        q0 = P + 2;
      end
      for (int q = P + 1; q < N; q++) begin
        if (q >= q0 && !done && q < int'(n) && (q == q0 || ms[q])) begin
          x = patx[q];
          if (q != q0 && x == CH_RBRACK) begin
            done = 1'b1;
            endq = q + 1;
          end else begin
            rng = ((q + 2) < int'(n)) && patx[q+1] == CH_DASH && patx[q+2] != CH_RBRACK;
            if (rng) begin
              if (fc >= fold_byte(fold_en, x) && fc <= fold_byte(fold_en, patx[q+2]))
                found = 1'b1;
              ms[q+3] = 1'b1;
            end else begin
              if (fc == fold_byte(fold_en, x)) found = 1'b1;
              ms[q+1] = 1'b1;
            end
          end
        end
      end
      cls_bad = !done;
      hit = found != neg;
    end
  end

  // Closed activity and forward carry over wildcards
  logic live;
  assign live = (P < int'(n));
  assign cur = (active && (P <= int'(n))) || carry_in;
  assign flags.wild = (patx[P] == CH_STAR) || (patx[P] == CH_QMARK);
  assign flags.bad = cls_bad;
  assign carry_out = cur && live && flags.wild;
  assign end_pos = PW'(endq);

  // Next-position drive
  always_comb begin
    drive = '0;
    if (cur && live) begin
      if (patx[P] == CH_STAR) begin
        drive[P] = 1'b1;
      end else if (hit && !cls_bad && endq <= int'(n)) begin
        drive[endq] = 1'b1;
      end
    end
  end

endmodule

### verif/gwm_checker.sv
module gwm_checker import gwm_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           name_byte,
  input  logic                 name_end,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 matched,
  input  logic                 pattern_bad,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   names_seen,
  output int                   hit_count,
  output int                   bad_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic hit;
    logic bad;
  } verdict_t;

  // shadow of the pattern registers and the live position set
  logic [63:0]          pat_word [4];
  logic [5:0]           pat_len_reg;
  logic                 fold_en;
  logic [PATTERN_MAX:0] live_pos;
  verdict_t             verdict_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    names_seen = 0;
    hit_count  = 0;
    bad_count  = 0;
  end

  function automatic int used_len();
    int n;
    n = pat_len_reg;
    return (n > PATTERN_MAX) ? PATTERN_MAX : n;
  endfunction

  function automatic logic [7:0] pat_at(int i);
    if (i >= 32) return 8'h00;
    return pat_word[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic logic [7:0] lower(logic [7:0] c);
    if (fold_en && c >= "A" && c <= "Z") return c + 8'd32;
    return c;
  endfunction

  // Walk one element from p: returns the position after it, -1 if a class never closes.
  function automatic int element_end(int p, int n, logic [7:0] c, output logic hit);
    logic [7:0] b;
    int q;
    logic neg, found, first;
    b = pat_at(p);
    hit = 1'b0;
    neg = 1'b0;
    found = 1'b0;
    first = 1'b1;
    if (b == CH_STAR || b == CH_QMARK) begin
      hit = 1'b1;
      return p + 1;
    end
    if (b != CH_LBRACK) begin
      hit = (lower(b) == lower(c));
      return p + 1;
    end
    q = p + 1;
    if (q < n && pat_at(q) == CH_CARET) begin
      neg = 1'b1;
      q++;
    end
    forever begin
      if (q >= n) return -1;
      if (!first && pat_at(q) == CH_RBRACK) break;
      first = 1'b0;
      if (q + 2 < n && pat_at(q + 1) == CH_DASH && pat_at(q + 2) != CH_RBRACK) begin
        if (lower(c) >= lower(pat_at(q)) && lower(c) <= lower(pat_at(q + 2))) found = 1'b1;
        q += 3;
      end else begin
        if (lower(c) == lower(pat_at(q))) found = 1'b1;
        q++;
      end
    end
    hit = found ^ neg;
    return q + 1;
  endfunction

  function automatic logic has_open_class(int n);
    int p;
    int r;
    logic h;
    p = 0;
    while (p < n) begin
      r = element_end(p, n, 8'h00, h);
      if (r < 0) return 1'b1;
      p = r;
    end
    return 1'b0;
  endfunction

  task automatic report_miss(string what, logic want, logic got);
    $display("[%0t] mismatch on %s: expected %0b, got %0b", $realtime, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    int n;
    int r;
    logic h;
    logic [PATTERN_MAX:0] cur;
    logic [PATTERN_MAX:0] nxt;
    verdict_t v;
    if (rst) begin
      for (int i = 0; i < 4; i++) pat_word[i] = '0;
      pat_len_reg = '0;
      fold_en = 1'b0;
      live_pos = '0;
      live_pos[0] = 1'b1;
      verdict_q.delete();
    end else begin
      // results against oldest expectation
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          report_miss("result item presence", 1'b0, 1'b1);
        end else begin
          v = verdict_q.pop_front();
          if (matched !== v.hit) report_miss("matched", v.hit, matched);
          if (pattern_bad !== v.bad) report_miss("pattern_bad", v.bad, pattern_bad);
        end
      end
      // advance the position set on each name item, under the registers before this edge
      if (in_valid && !in_stall) begin
        n = used_len();
        cur = '0;
        for (int p = 0; p <= n; p++) cur[p] = live_pos[p];
        for (int p = 0; p < n; p++)
          if (cur[p] && (pat_at(p) == CH_STAR || pat_at(p) == CH_QMARK)) cur[p + 1] = 1'b1;
        if (name_end) begin
          v.bad = has_open_class(n);
          v.hit = !v.bad && cur[n];
          verdict_q.push_back(v);
          names_seen++;
          if (v.hit) hit_count++;
          if (v.bad) bad_count++;
          live_pos = '0;
          live_pos[0] = 1'b1;
        end else begin
          nxt = '0;
          for (int p = 0; p < n; p++) begin
            if (cur[p]) begin
              if (pat_at(p) == CH_STAR) begin
                nxt[p] = 1'b1;
              end else begin
                r = element_end(p, n, name_byte, h);
                if (r >= 0 && h && r <= n) nxt[r] = 1'b1;
              end
            end
          end
          live_pos = nxt;
        end
      end
      // register writes take effect for the next item
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_CHARS_LOW:      pat_word[0] = cfg_data;
          REG_CHARS_MID_LOW:  pat_word[1] = cfg_data;
          REG_CHARS_MID_HIGH: pat_word[2] = cfg_data;
          REG_CHARS_HIGH:     pat_word[3] = cfg_data;
          REG_LENGTH:         pat_len_reg = cfg_data[5:0];
          REG_FOLD_CASE:      fold_en = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending = verdict_q.size();
  end

endmodule

### verif/tb_top.sv
module tb_top;
  import gwm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_GOAL   = 650;
  localparam int CYCLE_LIMIT = 200000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           name_byte = '0;
  logic                 name_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 matched;
  logic                 pattern_bad;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  int fail_count, pending, names_seen, hit_count, bad_count;
  int items_sent = 0;
  int loads = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  always #5 clk = ~clk;

  glob_wildcard_matcher i_dut (.*);

  gwm_checker i_checker (.*);

  // output side stalls at random
  always @(negedge clk) out_stall <= !quiet && ($urandom_range(0, 99) < 7);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_item(logic [7:0] b, logic e);
    if (!quiet && $urandom_range(0, 99) < 7) repeat ($urandom_range(1, 3)) @(negedge clk);
    in_valid = 1'b1;
    name_byte = b;
    name_end = e;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    items_sent++;
  endtask

  task automatic send_name(logic [7:0] nm [$], bit close);
    foreach (nm[i]) push_item(nm[i], 1'b0);
    if (close) push_item(8'($urandom), 1'b1);
  endtask

  task automatic cfg_write(cfg_reg_t r, logic [63:0] d);
    cfg_valid = 1'b1;
    cfg_index = r;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait out all outstanding results, then let the result register settle
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // bytes beyond the pattern are filled with junk so every data bit toggles
  task automatic load_pattern(logic [7:0] pat [$], int len, bit fold);
    logic [63:0] w [4];
    drain();
    for (int i = 0; i < 32; i++)
      w[i / 8][(i % 8) * 8 +: 8] = (i < pat.size()) ? pat[i] : 8'($urandom);
    cfg_write(REG_CHARS_LOW, w[0]);
    cfg_write(REG_CHARS_MID_LOW, w[1]);
    cfg_write(REG_CHARS_MID_HIGH, w[2]);
    cfg_write(REG_CHARS_HIGH, w[3]);
    cfg_write(REG_LENGTH, 64'(len));
    cfg_write(REG_FOLD_CASE, 64'(fold));
    loads++;
  endtask

  function automatic void to_bytes(string s, ref logic [7:0] q [$]);
    q.delete();
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_byte();
    string alpha;
    alpha = "abAZz]-*?[^";
    if ($urandom_range(0, 99) < 70) return alpha[$urandom_range(0, alpha.len() - 1)];
    return 8'($urandom);
  endfunction

  // name that follows the pattern, then maybe one corrupted byte
  function automatic void name_for(logic [7:0] pat [$], int n, ref logic [7:0] nm [$]);
    int p;
    int q;
    logic [7:0] c;
    nm.delete();
    p = 0;
    while (p < n && p < pat.size()) begin
      c = pat[p];
      if (c == CH_STAR) begin
        repeat ($urandom_range(0, 3)) nm.push_back(pick_byte());
        p++;
      end else if (c == CH_QMARK) begin
        if ($urandom_range(0, 1)) nm.push_back(pick_byte());
        p++;
      end else if (c == CH_LBRACK) begin
        q = p + 1;
        if (q < pat.size() && pat[q] == CH_CARET) begin
          nm.push_back(pick_byte());
          q++;
        end else begin
          nm.push_back(q < pat.size() ? pat[q] : pick_byte());
        end
        q++;
        while (q < pat.size() && pat[q] != CH_RBRACK) q++;
        p = q + 1;
      end else begin
        nm.push_back(($urandom_range(0, 3) == 0) ? (c ^ 8'h20) : c);
        p++;
      end
    end
    if (nm.size() > 0 && $urandom_range(0, 99) < 25)
      nm[$urandom_range(0, nm.size() - 1)] = 8'($urandom);
  endfunction

  initial begin
    logic [7:0] pat [$];
    logic [7:0] nm [$];
    int n;
    int phase;

    repeat (9) @(negedge clk);
    rst = 1'b0;

    // reset state: empty pattern against empty and one-byte names
    nm.delete();
    send_name(nm, 1'b1);
    to_bytes("a", nm); send_name(nm, 1'b1);

    // star and optional byte, exact then folded case
    to_bytes("a*b?c", pat); load_pattern(pat, pat.size(), 1'b0);
    to_bytes("aXbc", nm); send_name(nm, 1'b1);
    to_bytes("ABC", nm); send_name(nm, 1'b1);
    load_pattern(pat, pat.size(), 1'b1);
    to_bytes("AbC", nm); send_name(nm, 1'b1);

    // class with a leading bracket member and a range
    to_bytes("[]a-c]", pat); load_pattern(pat, pat.size(), 1'b0);
    to_bytes("]", nm); send_name(nm, 1'b1);
    to_bytes("d", nm); send_name(nm, 1'b1);

    // negated range: a byte in the range must not match
    to_bytes("[^a-c]", pat); load_pattern(pat, pat.size(), 1'b0);
    to_bytes("b", nm); send_name(nm, 1'b1);
    to_bytes("z", nm); send_name(nm, 1'b1);

    // unterminated class
    to_bytes("[ab", pat); load_pattern(pat, pat.size(), 1'b0);
    to_bytes("a", nm); send_name(nm, 1'b1);

    // length beyond the register bytes, all wildcards; zero bytes
    pat.delete();
    repeat (32) pat.push_back(CH_STAR);
    load_pattern(pat, 63, 1'b0);
    nm.delete(); send_name(nm, 1'b1);
    pat = '{8'h00, CH_QMARK};
    load_pattern(pat, 2, 1'b0);
    nm = '{8'h00, 8'hFF}; send_name(nm, 1'b1);

    // random patterns, each with a handful of names
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      quiet = (phase >= 20 && phase < 35);
      pat.delete();
      n = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(0, 8);
      repeat (n) pat.push_back(pick_byte());
      // odd phases of the length register, including the overlong ones
      if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 63);
      load_pattern(pat, n, 1'($urandom));
      if (phase == 40) drain();
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 99) < 15) begin
          nm.delete();
          repeat ($urandom_range(0, 6)) nm.push_back(8'($urandom));
        end else begin
          name_for(pat, n, nm);
        end
        send_name(nm, 1'b1);
      end
      // leave a name open across the next reload now and then
      if ($urandom_range(0, 9) == 0) begin
        name_for(pat, n, nm);
        send_name(nm, 1'b0);
      end
      phase++;
    end
    quiet = 1'b0;
    push_item(8'h00, 1'b1);

    drain();
    repeat (10) @(negedge clk);
    $display("Ran %0d items in %0d names over %0d pattern loads", items_sent, names_seen, loads);
    $display("Names matched: %0d, bad patterns seen: %0d", hit_count, bad_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
src/gwm_pkg.sv
src/gwm_cell.sv
src/glob_wildcard_matcher.sv
verif/gwm_checker.sv
verif/tb_top.sv
